/* hw/rtl/rcp_pkg.sv */
// rcp_pkg: shared types and constants for the request stream parser.
// Used by resp_command_parser_core and rcp_port_checker. No dependencies.
`default_nettype none

package rcp_pkg;

  // Characters the parser reacts to
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam int unsigned IdxW = 10;

  // Packed output beat layout
  localparam int unsigned TdataW = 88;
  localparam int unsigned TuserW = 6;

  typedef enum logic [2:0] {
    EV_STR_BYTE = 3'd0,
    EV_STR_END  = 3'd1,
    EV_INTEGER  = 3'd2,
    EV_ARR_HDR  = 3'd3,
    EV_BULK_HDR = 3'd4,
    EV_ERROR    = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    VT_SIMPLE = 3'd0,
    VT_ERRSTR = 3'd1,
    VT_INT    = 3'd2,
    VT_BULK   = 3'd3,
    VT_ARRAY  = 3'd4
  } vtype_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_EMPTY     = 3'd1,
    ERR_BAD_TYPE  = 3'd2,
    ERR_BAD_NUM   = 3'd3,
    ERR_NOT_BULK  = 3'd4,
    ERR_TOO_LARGE = 3'd5
  } err_e;

  typedef enum logic [4:0] {
    PH_TYPE = 5'b00001,
    PH_STR  = 5'b00010,
    PH_NUM  = 5'b00100,
    PH_BODY = 5'b01000,
    PH_SKIP = 5'b10000
  } phase_e;

  typedef struct packed {
    logic started;   // past leading blanks
    logic neg;
    logic stopped;   // hit a non-digit
    logic ovf;
  } num_flags_t;

  typedef struct packed {
    event_e          ev;
    vtype_e          vt;
    logic [7:0]      data;
    logic [63:0]     num;
    logic            is_null;
    logic [IdxW-1:0] idx;
    logic            in_arr;
    err_e            err;
    logic            last;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/resp_command_parser_core.sv */
// resp_command_parser_core: byte-stream parser for a request wire protocol.
// Depends on rcp_pkg.
`default_nettype none

// Takes one protocol byte per beat on the slave stream and gives at most one
// event beat per input byte on the master stream. Some bytes give no event:
// a type byte that opens a line, CR in a header line, blanks, sign, digit and
// trailing bytes of a number line, the first bulk trailer byte, and skipped
// bytes after an error. Every byte is handled by the logic between the
// parser state registers and the output register, so the sustained rate is
// one byte per clock unless the master side stalls. The output register is
// the only buffer: s_axis_tready_o is high whenever that register is empty
// or is being drained in the same cycle, so a stalled master side stalls
// input after one beat. The longest path is the decimal accumulate step
// (times ten plus digit, 68 bits, compared against the signed limit).
// Output tdata, low bit first: data_byte[7:0], number[71:8], is_null[72],
// element_index[82:73], in_array[83], error_code[86:84], zero pad [87].
// tuser: event_res[2:0], value_type[5:3]. tlast marks the beat that ends or
// abandons the top-level message. command_only resets to 1 and is written on
// the cfg channel, which is always ready; write it only while idle.
module resp_command_parser_core
  import rcp_pkg::*;
#(
  parameter int unsigned MAX_BULK_LEN = 1048576,
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // config write channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_data_i,     // command_only
  // input byte stream
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [7:0]        s_axis_tdata_i, // in_byte[7:0]
  // event stream
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [TdataW-1:0]      m_axis_tdata_o, // data_byte, number, is_null,
                                                 // element_index, in_array,
                                                 // error_code, pad
  output logic [TuserW-1:0]      m_axis_tuser_o, // event_res, value_type
  output logic                   m_axis_tlast_o  // message_end
);

  localparam int unsigned BlenW = $clog2(MAX_BULK_LEN + 3);
  localparam int unsigned ElemW = $clog2(MAX_ELEMENTS + 1);

  localparam logic [67:0] LimI64Pos = 68'h0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [67:0] LimI64Neg = 68'h0_8000_0000_0000_0000;
  localparam logic [67:0] LimI32Pos = 68'h0_0000_0000_7FFF_FFFF;
  localparam logic [67:0] LimI32Neg = 68'h0_0000_0000_8000_0000;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic              cmd_only_q;
  phase_e            phase_q, phase_d;
  vtype_e            kind_q, kind_d;
  logic [63:0]       accum_q, accum_d;
  num_flags_t        flags_q, flags_d;
  logic              have_digit_q, have_digit_d;
  logic [BlenW-1:0]  bytes_left_q, bytes_left_d;
  logic [ElemW-1:0]  elems_left_q, elems_left_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              in_arr_q, in_arr_d;

  logic              out_vld_q;
  result_t           out_q;

  logic              in_acc;
  logic [7:0]        c;
  result_t           res;
  logic              res_vld;

  // completion / failure requests from the phase logic
  logic              do_cmp;
  event_e            cmp_ev;
  vtype_e            cmp_vt;
  logic [63:0]       cmp_num;
  logic              cmp_null;
  logic              do_fail;
  err_e              fail_code;
  phase_e            fail_next;

  // number helpers
  logic              is_blank, is_digit;
  logic [3:0]        digit;
  logic [67:0]       prod, lim;
  logic [63:0]       signed_val;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = ~out_vld_q | m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign c               = s_axis_tdata_i;

  assign is_blank = (c == ChSpace) || (c == ChTab) || (c == ChVt) || (c == ChFf);
  assign is_digit = (c >= ChZero) && (c <= ChNine);
  assign digit    = 4'(c - ChZero);
  // accum * 10 + digit; overflow when this exceeds the limit
  assign prod = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} + {64'd0, digit};
  always_comb begin
    if (kind_q == VT_INT) lim = flags_q.neg ? LimI64Neg : LimI64Pos;
    else                  lim = flags_q.neg ? LimI32Neg : LimI32Pos;
  end
  assign signed_val = flags_q.neg ? (64'd0 - accum_q) : accum_q;

  // ---------------------------------------------------------------------------
  // Per-byte next state and result
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d      = phase_q;
    kind_d       = kind_q;
    accum_d      = accum_q;
    flags_d      = flags_q;
    have_digit_d = have_digit_q;
    bytes_left_d = bytes_left_q;
    elems_left_d = elems_left_q;
    idx_d        = idx_q;
    in_arr_d     = in_arr_q;

    res         = '0;
    res.ev      = EV_STR_BYTE;
    res.vt      = VT_SIMPLE;
    res.err     = ERR_NONE;
    res.idx     = in_arr_q ? idx_q : '0;
    res.in_arr  = in_arr_q;
    res_vld     = 1'b0;

    do_cmp    = 1'b0;
    cmp_ev    = EV_STR_END;
    cmp_vt    = VT_SIMPLE;
    cmp_num   = '0;
    cmp_null  = 1'b0;
    do_fail   = 1'b0;
    fail_code = ERR_NONE;
    fail_next = PH_TYPE;

    case (phase_q)
      PH_STR: begin
        if (c == ChLf) begin
          do_cmp = 1'b1;
          cmp_ev = EV_STR_END;
          cmp_vt = kind_q;
        end else if (c != ChCr) begin
          res_vld  = 1'b1;
          res.vt   = kind_q;
          res.data = c;
        end
      end

      PH_NUM: begin
        if (c == ChLf) begin
          if (!have_digit_q || flags_q.ovf) begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_NUM;
          end else if (kind_q == VT_INT) begin
            do_cmp  = 1'b1;
            cmp_ev  = EV_INTEGER;
            cmp_vt  = VT_INT;
            cmp_num = signed_val;
          end else if (kind_q == VT_BULK) begin
            if (flags_q.neg && (accum_q != '0)) begin
              do_cmp   = 1'b1;
              cmp_ev   = EV_BULK_HDR;
              cmp_vt   = VT_BULK;
              cmp_num  = signed_val;
              cmp_null = 1'b1;
            end else if (accum_q > 64'(MAX_BULK_LEN)) begin
              do_fail   = 1'b1;
              fail_code = ERR_TOO_LARGE;
            end else begin
              bytes_left_d = accum_q[BlenW-1:0] + BlenW'(2);
              phase_d      = PH_BODY;
              res_vld      = 1'b1;
              res.ev       = EV_BULK_HDR;
              res.vt       = VT_BULK;
              res.num      = signed_val;
            end
          end else begin
            // array header; only reached outside an array
            phase_d = PH_TYPE;
            if (flags_q.neg || (accum_q == '0)) begin
              res_vld  = 1'b1;
              res.ev   = EV_ARR_HDR;
              res.vt   = VT_ARRAY;
              res.num  = signed_val;
              res.last = 1'b1;
            end else if (accum_q > 64'(MAX_ELEMENTS)) begin
              do_fail   = 1'b1;
              fail_code = ERR_TOO_LARGE;
            end else begin
              res_vld      = 1'b1;
              res.ev       = EV_ARR_HDR;
              res.vt       = VT_ARRAY;
              res.num      = signed_val;
              in_arr_d     = 1'b1;
              elems_left_d = accum_q[ElemW-1:0];
              idx_d        = '0;
            end
          end
        end else if (c != ChCr && !flags_q.stopped) begin
          if (!flags_q.started && is_blank) begin
            // leading blank, skip
          end else if (!flags_q.started && (c == ChPlus)) begin
            flags_d.started = 1'b1;
          end else if (!flags_q.started && (c == ChMinus)) begin
            flags_d.started = 1'b1;
            flags_d.neg     = 1'b1;
          end else if (!is_digit) begin
            flags_d.started = 1'b1;
            flags_d.stopped = 1'b1;
          end else begin
            flags_d.started = 1'b1;
            have_digit_d    = 1'b1;
            if (!flags_q.ovf) begin
              if (prod > lim) flags_d.ovf = 1'b1;
              else            accum_d     = prod[63:0];
            end
          end
        end
      end

      PH_BODY: begin
        if (bytes_left_q > BlenW'(2)) begin
          bytes_left_d = bytes_left_q - BlenW'(1);
          res_vld      = 1'b1;
          res.vt       = VT_BULK;
          res.data     = c;
        end else if (bytes_left_q == BlenW'(2)) begin
          bytes_left_d = BlenW'(1);
        end else begin
          bytes_left_d = '0;
          do_cmp       = 1'b1;
          cmp_ev       = EV_STR_END;
          cmp_vt       = VT_BULK;
        end
      end

      PH_SKIP: begin
        if (c == ChLf) phase_d = PH_TYPE;
      end

      default: begin
        // awaiting a type byte
        if (c == ChCr) begin
          // dropped
        end else if (c == ChLf) begin
          do_fail   = 1'b1;
          fail_code = ERR_EMPTY;
        end else if (in_arr_q && (c != ChDollar)) begin
          do_fail   = 1'b1;
          fail_code = ERR_NOT_BULK;
          fail_next = PH_SKIP;
        end else if (!in_arr_q && cmd_only_q && (c != ChStar)) begin
          do_fail   = 1'b1;
          fail_code = ERR_BAD_TYPE;
          fail_next = PH_SKIP;
        end else begin
          accum_d      = '0;
          flags_d      = '0;
          have_digit_d = 1'b0;
          phase_d      = PH_NUM;
          case (c)
            ChPlus: begin
              kind_d  = VT_SIMPLE;
              phase_d = PH_STR;
            end
            ChMinus: begin
              kind_d  = VT_ERRSTR;
              phase_d = PH_STR;
            end
            ChColon:  kind_d = VT_INT;
            ChDollar: kind_d = VT_BULK;
            ChStar:   kind_d = VT_ARRAY;
            default: begin
              accum_d      = accum_q;
              flags_d      = flags_q;
              have_digit_d = have_digit_q;
              do_fail      = 1'b1;
              fail_code    = ERR_BAD_TYPE;
              fail_next    = PH_SKIP;
            end
          endcase
        end
      end
    endcase

    // value completes: report, then advance the array bookkeeping
    if (do_cmp) begin
      phase_d      = PH_TYPE;
      res_vld      = 1'b1;
      res.ev       = cmp_ev;
      res.vt       = cmp_vt;
      res.data     = '0;
      res.num      = cmp_num;
      res.is_null  = cmp_null;
      res.last     = in_arr_q ? (elems_left_q <= ElemW'(1)) : 1'b1;
      if (in_arr_q) begin
        elems_left_d = (elems_left_q != '0) ? elems_left_q - ElemW'(1) : '0;
        idx_d        = idx_q + IdxW'(1);
        if (elems_left_d == '0) begin
          in_arr_d = 1'b0;
          idx_d    = '0;
        end
      end
    end

    // any error drops the array and ends the message
    if (do_fail) begin
      phase_d      = fail_next;
      in_arr_d     = 1'b0;
      elems_left_d = '0;
      idx_d        = '0;
      res          = '0;
      res.ev       = EV_ERROR;
      res.vt       = VT_SIMPLE;
      res.err      = fail_code;
      res.last     = 1'b1;
      res_vld      = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_only_q <= 1'b1;
    end else if (cfg_valid_i) begin
      cmd_only_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TYPE;
      kind_q       <= VT_SIMPLE;
      accum_q      <= '0;
      flags_q      <= '0;
      have_digit_q <= 1'b0;
      bytes_left_q <= '0;
      elems_left_q <= '0;
      idx_q        <= '0;
      in_arr_q     <= 1'b0;
    end else if (in_acc) begin
      phase_q      <= phase_d;
      kind_q       <= kind_d;
      accum_q      <= accum_d;
      flags_q      <= flags_d;
      have_digit_q <= have_digit_d;
      bytes_left_q <= bytes_left_d;
      elems_left_q <= elems_left_d;
      idx_q        <= idx_d;
      in_arr_q     <= in_arr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_acc) begin
      out_vld_q <= res_vld;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_q.err, out_q.in_arr, out_q.idx, out_q.is_null,
                            out_q.num, out_q.data};
  assign m_axis_tuser_o  = {out_q.vt, out_q.ev};
  assign m_axis_tlast_o  = out_q.last;

endmodule

`default_nettype wire

/* hw/rtl/rcp_port_checker.sv */
// rcp_port_checker: port-level assertions for resp_command_parser_core,
// bound to the top level below. Depends on rcp_pkg.
`default_nettype none

module rcp_port_checker
  import rcp_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              m_axis_tvalid_o,
  input wire logic              m_axis_tready_i,
  input wire logic [TdataW-1:0] m_axis_tdata_o,
  input wire logic [TuserW-1:0] m_axis_tuser_o,
  input wire logic              m_axis_tlast_o
);

  logic is_err, is_byte;
  assign is_err  = m_axis_tvalid_o && (m_axis_tuser_o[2:0] == EV_ERROR);
  assign is_byte = m_axis_tvalid_o && (m_axis_tuser_o[2:0] == EV_STR_BYTE);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // an error always abandons the message
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_err |-> m_axis_tlast_o)
    else $error("error beat without message end");

  // an error drops the array context and carries no type
  a_err_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_err |-> (m_axis_tdata_o[83] == 1'b0) && (m_axis_tdata_o[82:73] == '0) &&
               (m_axis_tuser_o[5:3] == VT_SIMPLE) && (m_axis_tdata_o[86:84] != ERR_NONE))
    else $error("error beat carries element context");

  // payload bytes never end a message and carry no error
  a_byte_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_byte |-> !m_axis_tlast_o && (m_axis_tdata_o[86:84] == ERR_NONE))
    else $error("string byte marked as message end");

endmodule

bind resp_command_parser_core rcp_port_checker u_rcp_port_checker (.*);

`default_nettype wire
